[src/global_handle_table_defines.svh]
// Assertion macros for the handle table
`ifndef GLOBAL_HANDLE_TABLE_DEFINES_SVH
`define GLOBAL_HANDLE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define GHT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GHT_ASSERT_RST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GHT_ASSERT(label, clk, rst_n, prop, msg)
`define GHT_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

[src/ght_pkg.sv]
`default_nettype none
package ght_pkg;
	typedef enum logic [2:0] {
		REQ_ALLOC = 3'd0, REQ_FREE = 3'd1, REQ_LOCK = 3'd2,
		REQ_UNLOCK = 3'd3, REQ_QUERY = 3'd4, REQ_PURGE = 3'd5
	} req_t;
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_HANDLE = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
	localparam logic [2:0] ST_FULL       = 3'd3;
	localparam logic [2:0] ST_ZERO_SIZE  = 3'd4;
	localparam int REC_W = 96;
	typedef struct packed {
		logic [2:0]  req;
		logic [15:0] handle;
		logic [15:0] flags;
		logic [31:0] size;
		logic [15:0] owner;
		logic        bad_handle;
		logic        zero_size;
		logic        unknown;
	} cmd_t;
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] handle_out;
		logic [31:0] block_size;
		logic [15:0] block_flags;
		logic [15:0] lock_level;
		logic [6:0]  freed_count;
	} res_t;
endpackage
`default_nettype wire

[src/ght_ram.sv]
`default_nettype none
module ght_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[src/ght_front.sv]
`default_nettype none
module ght_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire logic [2:0]      req_type,
	input  wire logic [15:0]     handle_in,
	input  wire logic [15:0]     alloc_flags,
	input  wire logic [31:0]     alloc_size,
	input  wire logic [15:0]     owner_id,
	output logic                 cmd_valid,
	output ght_pkg::cmd_t        cmd,
	input  wire logic            cmd_take
);
	import ght_pkg::*;
	// two-entry command queue
	cmd_t q_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	cmd_t c;
	always_comb begin
		c.req = req_type;
		c.handle = handle_in;
		c.flags = alloc_flags;
		c.size = alloc_size;
		c.owner = owner_id;
		c.bad_handle = (handle_in == 16'd0);
		c.zero_size = (alloc_size == 32'd0);
		c.unknown = (req_type > REQ_PURGE);
	end
	assign full = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rd_q];
	wire logic do_push = push && !full;
	wire logic do_pop = cmd_take && cmd_valid;
	always_ff @(posedge clk) if (do_push) q_q[wr_q] <= c;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule
`default_nettype wire

[src/ght_back.sv]
`default_nettype none
`include "global_handle_table_defines.svh"
module ght_back #(
	parameter int ENTRIES = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [6:0]    cap,
	input  wire logic          cmd_valid,
	input  wire ght_pkg::cmd_t cmd,
	output logic               cmd_take,
	output logic               res_valid,
	output ght_pkg::res_t      res,
	input  wire logic          res_take
);
	import ght_pkg::*;
	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int HW = (CW > 7) ? CW : 7;

	typedef enum logic [5:0] {
		S_CLR = 6'b000001, S_IDLE = 6'b000010, S_RD = 6'b000100,
		S_CHK = 6'b001000, S_DONE = 6'b010000, S_OUT = 6'b100000
	} st_t;
	st_t st_q;

	// record: handle, flags, size, locks, owner
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [REC_W-1:0] wdata, rdata;
	ght_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	cmd_t c_q;
	logic [CW-1:0] idx_q, n_q;
	logic [15:0]   next_q;
	logic [HW-1:0] live_q;
	logic [6:0]    freed_q;
	res_t          r_q;

	logic [15:0] r_h, r_f, r_l, r_o;
	logic [31:0] r_s;
	assign {r_h, r_f, r_s, r_l, r_o} = rdata;

	logic [CW-1:0] cap_n;
	always_comb begin
		if (HW'(cap) > HW'(ENTRIES)) cap_n = CW'(ENTRIES);
		else cap_n = CW'(cap);
	end

	wire logic last = (idx_q + 1'b1 >= n_q);
	wire logic hit_free = (r_h == 16'd0);
	wire logic hit_h = (r_h == c_q.handle);
	wire logic hit_o = (r_h != 16'd0) && (r_o == c_q.owner);

	assign raddr = idx_q[AW-1:0];
	assign cmd_take = (st_q == S_IDLE) && cmd_valid;
	assign res_valid = (st_q == S_OUT);
	assign res = r_q;

	// early outcome of a new command, before any scan
	logic [2:0] idle_st;
	logic       idle_scan;
	always_comb begin
		idle_st = ST_OK;
		idle_scan = 1'b0;
		if (cmd.unknown || (cmd.req == REQ_PURGE && cmd.owner == 16'd0))
			idle_st = ST_OK;
		else if (cmd.req == REQ_ALLOC && cmd.zero_size)
			idle_st = ST_ZERO_SIZE;
		else if (cmd.req == REQ_ALLOC && live_q >= HW'(cap_n))
			idle_st = ST_FULL;
		else if (cmd.req != REQ_ALLOC && cmd.req != REQ_PURGE
			&& cmd.bad_handle)
			idle_st = ST_BAD_HANDLE;
		else if (cap_n == '0)
			idle_st = (cmd.req == REQ_PURGE) ? ST_OK
				: (cmd.req == REQ_ALLOC) ? ST_FULL : ST_NOT_FOUND;
		else idle_scan = 1'b1;
	end

	// scan ends on this slot
	logic chk_done;
	always_comb begin
		case (c_q.req)
			REQ_ALLOC: chk_done = hit_free || last;
			REQ_PURGE: chk_done = last;
			default: chk_done = hit_h || last;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = '0;
		if (st_q == S_CLR) we = 1'b1;
		if (st_q == S_CHK) begin
			case (c_q.req)
				REQ_ALLOC: if (hit_free) begin
					we = 1'b1;
					wdata = {next_q, c_q.flags, c_q.size, 16'd0, c_q.owner};
				end
				REQ_FREE: we = hit_h;
				REQ_LOCK: if (hit_h) begin
					we = 1'b1;
					wdata = {r_h, r_f, r_s, (r_l == 16'hFFFF) ? r_l : r_l + 16'd1, r_o};
				end
				REQ_UNLOCK: if (hit_h) begin
					we = 1'b1;
					wdata = {r_h, r_f, r_s, (r_l == 16'd0) ? r_l : r_l - 16'd1, r_o};
				end
				REQ_PURGE: we = hit_o;
				default: we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) if (st_q == S_IDLE && cmd_valid) c_q <= cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR; idx_q <= '0; n_q <= '0; next_q <= 16'd1;
			live_q <= '0; freed_q <= '0; r_q <= '0;
		end else begin
			case (st_q)
				S_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == CW'(ENTRIES - 1)) st_q <= S_IDLE;
				end
				S_IDLE: if (cmd_valid) begin
					idx_q <= '0; n_q <= cap_n; freed_q <= '0;
					r_q <= '{status: idle_st, default: '0};
					st_q <= idle_scan ? S_RD : S_DONE;
				end
				S_RD: st_q <= S_CHK;
				S_CHK: begin
					st_q <= chk_done ? S_DONE : S_RD;
					idx_q <= idx_q + 1'b1;
					case (c_q.req)
						REQ_ALLOC: if (hit_free) begin
							r_q.handle_out <= next_q;
							next_q <= (next_q == 16'hFFFF) ? 16'd1 : next_q + 16'd1;
							live_q <= live_q + 1'b1;
						end else if (last) begin
							r_q.status <= ST_FULL;
						end
						REQ_PURGE: begin
							if (hit_o) begin
								freed_q <= freed_q + 7'd1;
								if (live_q != '0) live_q <= live_q - 1'b1;
							end
							if (last)
								r_q.freed_count <= freed_q + {6'd0, hit_o};
						end
						default: if (hit_h) begin
							case (c_q.req)
								REQ_FREE: if (live_q != '0) live_q <= live_q - 1'b1;
								REQ_LOCK: r_q.lock_level <= (r_l == 16'hFFFF) ? r_l : r_l + 16'd1;
								REQ_UNLOCK: r_q.lock_level <= (r_l == 16'd0) ? r_l : r_l - 16'd1;
								REQ_QUERY: begin
									r_q.lock_level <= r_l;
									r_q.block_size <= r_s;
									r_q.block_flags <= r_f;
								end
								default: r_q.lock_level <= r_q.lock_level;
							endcase
						end else if (last) begin
							r_q.status <= ST_NOT_FOUND;
						end
					endcase
				end
				S_DONE: st_q <= S_OUT;
				S_OUT: if (res_take) st_q <= S_IDLE;
				default: st_q <= S_CLR;
			endcase
		end
	end

	`GHT_ASSERT(a_take_idle, clk, arst_n, cmd_take |=> (st_q != S_IDLE), "take not leaving idle")
	`GHT_ASSERT(a_live_cap, clk, arst_n, live_q <= HW'(ENTRIES), "live count over depth")
	`GHT_ASSERT(a_ok_out, clk, arst_n, (res_valid && r_q.status != ST_OK) |-> (r_q.freed_count == 7'd0), "error with freed count")
	`GHT_ASSERT_RST(a_no_wr_idle, clk, (st_q == S_IDLE) |-> !we, "write while idle")
endmodule
`default_nettype wire

[src/global_handle_table.sv]
// A request settled without a scan goes from idle through done to out; otherwise
// each slot visited takes a read and a check state, one RAM read port sets the step.
// Throughput: one request at a time; a two-entry command queue takes new work
// meanwhile. Reset: asynchronous, active low; then a clearing pass over every slot
// wipes the slot RAM before the first request is served.
`default_nettype none
module global_handle_table #(
	parameter int ENTRIES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  req_type,
	input  wire logic [15:0] handle_in,
	input  wire logic [15:0] alloc_flags,
	input  wire logic [31:0] alloc_size,
	input  wire logic [15:0] owner_id,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       status,
	output logic [15:0]      handle_out,
	output logic [31:0]      block_size,
	output logic [15:0]      block_flags,
	output logic [15:0]      lock_level,
	output logic [6:0]       freed_count,
	input  wire logic        cfg_we,
	input  wire logic [6:0]  cfg_wdata
);
	import ght_pkg::*;
	// capacity register, to be written only while idle; the block does not enforce it
	logic [6:0] cap_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= 7'd64;
		else if (cfg_we) cap_q <= cfg_wdata;
	end
	logic cmd_valid, cmd_take, res_valid;
	cmd_t cmd;
	res_t res;
	// front: classify and queue the transfer
	ght_front u_front (
		.clk, .arst_n, .push, .full, .req_type, .handle_in, .alloc_flags,
		.alloc_size, .owner_id, .cmd_valid, .cmd, .cmd_take
	);
	// back: scan the slot table, hold result until popped
	ght_back #(.ENTRIES(ENTRIES)) u_back (
		.clk, .arst_n, .cap(cap_q), .cmd_valid, .cmd, .cmd_take,
		.res_valid, .res, .res_take(pop)
	);
	assign empty = !res_valid;
	assign status = res.status;
	assign handle_out = res.handle_out;
	assign block_size = res.block_size;
	assign block_flags = res.block_flags;
	assign lock_level = res.lock_level;
	assign freed_count = res.freed_count;
endmodule
`default_nettype wire

[sim/ght_checker.sv]
`default_nettype none
module ght_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic        full,
	input  wire logic [2:0]  req_type,
	input  wire logic [15:0] handle_in,
	input  wire logic [15:0] alloc_flags,
	input  wire logic [31:0] alloc_size,
	input  wire logic [15:0] owner_id,
	input  wire logic        empty,
	input  wire logic        pop,
	input  wire logic [2:0]  status,
	input  wire logic [15:0] handle_out,
	input  wire logic [31:0] block_size,
	input  wire logic [15:0] block_flags,
	input  wire logic [15:0] lock_level,
	input  wire logic [6:0]  freed_count,
	input  wire logic        cfg_we,
	input  wire logic [6:0]  cfg_wdata,
	output int               fails,
	output int               outstanding,
	output logic [15:0]      next_hnd
);
	import ght_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;

	// shadow of the slot table
	logic [15:0] tab_hnd   [DEPTH];
	logic [15:0] tab_flags [DEPTH];
	logic [31:0] tab_size  [DEPTH];
	logic [15:0] tab_locks [DEPTH];
	logic [15:0] tab_owner [DEPTH];
	logic [15:0] hnd_ctr;
	logic [6:0]  live;
	logic [6:0]  cap;
	res_t        expected_res [$];
	int          fail_cnt;

	function automatic void drop_slot(int i);
		tab_hnd[i]   = '0;
		tab_flags[i] = '0;
		tab_size[i]  = '0;
		tab_locks[i] = '0;
		tab_owner[i] = '0;
		if (live != 0)
			live = live - 7'd1;
	endfunction

	function automatic res_t serve(logic [2:0] rq, logic [15:0] h, logic [15:0] fl,
			logic [31:0] sz, logic [15:0] own);
		res_t r;
		int   n;
		int   hit;
		r   = '0;
		n   = (cap > DEPTH) ? DEPTH : int'(cap);
		hit = -1;
		case (rq)
			REQ_ALLOC: begin
				if (sz == 0)
					r.status = ST_ZERO_SIZE;
				else if (int'(live) >= n)
					r.status = ST_FULL;
				else begin
					for (int i = 0; i < n; i++)
						if (hit < 0 && tab_hnd[i] == 0)
							hit = i;
					if (hit < 0)
						r.status = ST_FULL;
					else begin
						tab_hnd[hit]   = hnd_ctr;
						tab_flags[hit] = fl;
						tab_size[hit]  = sz;
						tab_locks[hit] = '0;
						tab_owner[hit] = own;
						r.handle_out   = hnd_ctr;
						hnd_ctr        = hnd_ctr + 16'd1;
						if (hnd_ctr == 0)
							hnd_ctr = 16'd1;
						live = live + 7'd1;
					end
				end
			end
			REQ_FREE, REQ_LOCK, REQ_UNLOCK, REQ_QUERY: begin
				if (h == 0)
					r.status = ST_BAD_HANDLE;
				else begin
					// duplicates after wrap: lowest slot wins
					for (int i = 0; i < n; i++)
						if (hit < 0 && tab_hnd[i] == h)
							hit = i;
					if (hit < 0)
						r.status = ST_NOT_FOUND;
					else if (rq == REQ_FREE)
						drop_slot(hit);
					else if (rq == REQ_LOCK) begin
						if (tab_locks[hit] != 16'hFFFF)
							tab_locks[hit] = tab_locks[hit] + 16'd1;
						r.lock_level = tab_locks[hit];
					end else if (rq == REQ_UNLOCK) begin
						if (tab_locks[hit] != 0)
							tab_locks[hit] = tab_locks[hit] - 16'd1;
						r.lock_level = tab_locks[hit];
					end else begin
						r.block_size  = tab_size[hit];
						r.block_flags = tab_flags[hit];
						r.lock_level  = tab_locks[hit];
					end
				end
			end
			REQ_PURGE: begin
				if (own != 0)
					for (int i = 0; i < n; i++)
						if (tab_hnd[i] != 0 && tab_owner[i] == own) begin
							drop_slot(i);
							r.freed_count = r.freed_count + 7'd1;
						end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int field_diff(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v === act_v)
			return 0;
		$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
			$time, name, exp_v, act_v);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t exp_r;
		int   bad;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				tab_hnd[i]   = '0;
				tab_flags[i] = '0;
				tab_size[i]  = '0;
				tab_locks[i] = '0;
				tab_owner[i] = '0;
			end
			hnd_ctr = 16'd1;
			live    = '0;
			cap     = 7'd64;
			fail_cnt = 0;
			expected_res.delete();
			fails       <= 0;
			outstanding <= 0;
			next_hnd    <= 16'd1;
		end else begin
			if (cfg_we)
				cap = cfg_wdata;
			// result side first: a transfer in flight cannot be the one pushed now
			if (pop && !empty) begin
				if (expected_res.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual status %0d",
						$time, status);
					fail_cnt++;
				end else begin
					exp_r = expected_res.pop_front();
					bad = field_diff("status", exp_r.status, status)
						+ field_diff("handle_out", exp_r.handle_out, handle_out)
						+ field_diff("block_size", exp_r.block_size, block_size)
						+ field_diff("block_flags", exp_r.block_flags, block_flags)
						+ field_diff("lock_level", exp_r.lock_level, lock_level)
						+ field_diff("freed_count", exp_r.freed_count, freed_count);
					if (bad != 0)
						fail_cnt++;
				end
			end
			if (push && !full)
				expected_res.push_back(serve(req_type, handle_in, alloc_flags,
					alloc_size, owner_id));
			fails       <= fail_cnt;
			outstanding <= expected_res.size();
			next_hnd    <= hnd_ctr;
		end
	end
endmodule
`default_nettype wire

[sim/tb_global_handle_table.sv]
`default_nettype none
module tb_global_handle_table;
	import ght_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [2:0]  req_type;
	logic [15:0] handle_in;
	logic [15:0] alloc_flags;
	logic [31:0] alloc_size;
	logic [15:0] owner_id;
	logic        empty;
	logic        pop;
	logic [2:0]  status;
	logic [15:0] handle_out;
	logic [31:0] block_size;
	logic [15:0] block_flags;
	logic [15:0] lock_level;
	logic [6:0]  freed_count;
	logic        cfg_we;
	logic [6:0]  cfg_wdata;
	int          fails;
	int          outstanding;
	logic [15:0] next_hnd;

	// stimulus controls shared with the pop process
	bit          no_gaps;
	bit          hold_req;

	localparam logic [2:0] REQ_UNKNOWN6 = 3'd6;
	localparam logic [2:0] REQ_UNKNOWN7 = 3'd7;

	global_handle_table #(.ENTRIES(64)) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req_type    (req_type),
		.handle_in   (handle_in),
		.alloc_flags (alloc_flags),
		.alloc_size  (alloc_size),
		.owner_id    (owner_id),
		.empty       (empty),
		.pop         (pop),
		.status      (status),
		.handle_out  (handle_out),
		.block_size  (block_size),
		.block_flags (block_flags),
		.lock_level  (lock_level),
		.freed_count (freed_count),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	ght_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req_type    (req_type),
		.handle_in   (handle_in),
		.alloc_flags (alloc_flags),
		.alloc_size  (alloc_size),
		.owner_id    (owner_id),
		.empty       (empty),
		.pop         (pop),
		.status      (status),
		.handle_out  (handle_out),
		.block_size  (block_size),
		.block_flags (block_flags),
		.lock_level  (lock_level),
		.freed_count (freed_count),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.fails       (fails),
		.outstanding (outstanding),
		.next_hnd    (next_hnd)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog. Under 1000 requests, each at the longest table scan, stay well
	// below 2 ms; allow many times that.
	initial begin
		#50ms;
		$display("global_handle_table regression: fail");
		$finish;
	end

	// Result side. Values are sampled at the edge before any update lands, so
	// after its initial value pop is only driven by NBA here. One long hold-off lets
	// the command queue fill and push back on the sender.
	initial begin
		bit held;
		held = 1'b0;
		pop  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (400) @(posedge clk);
			end else
				pop <= no_gaps ? 1'b1 : ($urandom_range(99) >= 33);
		end
	end

	// One transfer on the request side; returns on the accepting edge.
	task automatic send(logic [2:0] rq, logic [15:0] h, logic [15:0] fl,
			logic [31:0] sz, logic [15:0] own);
		if (!no_gaps && $urandom_range(99) < 33) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push        <= 1'b1;
		req_type    <= rq;
		handle_in   <= h;
		alloc_flags <= fl;
		alloc_size  <= sz;
		owner_id    <= own;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// Capacity changes only once every expected result has been taken.
	task automatic set_capacity(logic [6:0] v);
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Random requests: mostly live handles and a few owners, with some noise.
	task automatic random_burst(int count);
		logic [2:0]  rq;
		logic [15:0] h;
		logic [31:0] sz;
		logic [15:0] own;
		int          pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < 35)      rq = REQ_ALLOC;
			else if (pick < 50) rq = REQ_FREE;
			else if (pick < 63) rq = REQ_LOCK;
			else if (pick < 73) rq = REQ_UNLOCK;
			else if (pick < 87) rq = REQ_QUERY;
			else if (pick < 94) rq = REQ_PURGE;
			else                rq = $urandom_range(1) ? REQ_UNKNOWN6 : REQ_UNKNOWN7;
			pick = $urandom_range(99);
			if (pick < 80)      h = next_hnd - 16'($urandom_range(1, 24));
			else if (pick < 90) h = 16'($urandom);
			else                h = '0;
			pick = $urandom_range(99);
			if (pick < 85)      sz = $urandom_range(1, 32'hFFFF_FFFF);
			else if (pick < 93) sz = '0;
			else                sz = 32'hFFFF_FFFF;
			pick = $urandom_range(99);
			if (pick < 85)      own = 16'($urandom_range(1, 4));
			else if (pick < 92) own = 16'($urandom);
			else                own = '0;
			send(rq, h, 16'($urandom), sz, own);
		end
	endtask

	initial begin
		logic [15:0] h0;
		arst_n      = 1'b0;
		push        = 1'b0;
		req_type    = '0;
		handle_in   = '0;
		alloc_flags = '0;
		alloc_size  = '0;
		owner_id    = '0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		no_gaps     = 1'b0;
		hold_req    = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, each request kind, error paths
		set_capacity(7'd64);
		h0 = next_hnd;
		send(REQ_ALLOC, '0, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send(REQ_ALLOC, '0, 16'h0000, 32'h0000_0001, 16'h0001);
		send(REQ_ALLOC, '0, 16'h5A5A, 32'h0000_0000, 16'h0001); // zero size
		send(REQ_QUERY, h0, '0, '0, '0);
		send(REQ_UNLOCK, h0, '0, '0, '0);                       // floor at zero
		send(REQ_LOCK, h0, '0, '0, '0);
		send(REQ_LOCK, h0, '0, '0, '0);
		send(REQ_UNLOCK, h0, '0, '0, '0);
		send(REQ_QUERY, 16'hFFFF, '0, '0, '0);                  // missing handle
		send(REQ_FREE, '0, '0, '0, '0);                         // zero handle
		send(REQ_LOCK, '0, '0, '0, '0);
		send(REQ_UNLOCK, '0, '0, '0, '0);
		send(REQ_QUERY, '0, '0, '0, '0);
		send(REQ_PURGE, '0, '0, '0, '0);                        // zero owner
		send(REQ_UNKNOWN6, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send(REQ_UNKNOWN7, h0, '0, '0, '0);
		send(REQ_FREE, h0, '0, '0, '0);
		send(REQ_FREE, h0, '0, '0, '0);                         // already gone
		send(REQ_PURGE, '0, '0, '0, 16'h0001);

		// shrunk and zero capacity: full table, hidden records
		set_capacity(7'd1);
		send(REQ_ALLOC, '0, 16'h1234, 32'd100, 16'h0002);
		send(REQ_ALLOC, '0, 16'h1234, 32'd100, 16'h0002);       // table full
		set_capacity(7'd0);
		send(REQ_ALLOC, '0, 16'h1, 32'd1, 16'h3);
		send(REQ_QUERY, next_hnd - 16'd1, '0, '0, '0);
		send(REQ_PURGE, '0, '0, '0, 16'h0002);

		// a short lock run on one block, back to back
		set_capacity(7'd1);
		send(REQ_PURGE, '0, '0, '0, 16'h0002);
		set_capacity(7'd1);
		no_gaps = 1'b1;
		h0 = next_hnd;
		send(REQ_ALLOC, '0, 16'h0F0F, 32'd64, 16'h0007);
		repeat (4) send(REQ_LOCK, h0, '0, '0, '0);
		send(REQ_QUERY, h0, '0, '0, '0);
		send(REQ_UNLOCK, h0, '0, '0, '0);
		send(REQ_FREE, h0, '0, '0, '0);
		no_gaps = 1'b0;

		// random phases over several capacities, with one long result stall
		set_capacity(7'd64);
		hold_req = 1'b1;
		random_burst(150);
		no_gaps = 1'b1;
		random_burst(150);
		no_gaps = 1'b0;
		random_burst(150);
		set_capacity(7'd8);
		random_burst(200);
		set_capacity(7'd127);
		random_burst(150);
		set_capacity(7'd3);
		random_burst(100);

		// drain, then let the block settle
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (140) @(posedge clk);
		if (fails == 0)
			$display("global_handle_table regression: pass");
		else
			$display("global_handle_table regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
